// ===== rtl/core/rwb_pkg.sv =====
package rwb_pkg;

    // Largest supported image
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Pixel and channel widths
    localparam int CHAN_W = 8;
    localparam int NUM_CHAN = 3;
    localparam int PIX_W  = NUM_CHAN * CHAN_W;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Register reset values (raw, before clamping)
    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 480;

    // Input item codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // Counter and dimension widths
    localparam int WIDTH_W   = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int IN_ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int OUT_ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // 8*center + eight neighbors needs four extra bits
    localparam int SUM_W = CHAN_W + 4;

    // Window geometry: index = column*3 + row, column 0 oldest, row 0 top
    localparam int WIN_SIDE = 3;
    localparam int WIN_N    = WIN_SIDE * WIN_SIDE;
    localparam int WIN_IDX_W = $clog2(WIN_N);

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic              action;
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } pix_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              last_of_frame;
    } res_item_t;

    // One line store entry: the two previous rows at one column
    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_entry_t;

    // Per-item control seen by the window and result stages
    typedef struct packed {
        logic emit;
        logic last;
        logic at_left;
        logic at_right;
        logic at_top;
        logic at_bottom;
    } win_ctrl_t;

    // Per-item control produced at input transfer
    typedef struct packed {
        logic             drop;
        logic             pixel;
        logic [COL_W-1:0] col;
        win_ctrl_t        win;
    } item_ctrl_t;

    // Width register value: zero acts as one, oversize acts as maximum
    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [CFG_DATA_W-1:0] v);
        logic [WIDTH_W-1:0] r;
        if (v == '0)
            r = WIDTH_W'(1);
        else if (32'(v) > MAX_WIDTH)
            r = WIDTH_W'(MAX_WIDTH);
        else
            r = WIDTH_W'(v);
        return r;
    endfunction

    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [CFG_DATA_W-1:0] v);
        logic [HEIGHT_W-1:0] r;
        if (v == '0)
            r = HEIGHT_W'(1);
        else if (32'(v) > MAX_HEIGHT)
            r = HEIGHT_W'(MAX_HEIGHT);
        else
            r = HEIGHT_W'(v);
        return r;
    endfunction

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  =
        clamp_width(CFG_DATA_W'(RST_FRAME_WIDTH));
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT =
        clamp_height(CFG_DATA_W'(RST_FRAME_HEIGHT));

    // Channel 0 is red (top byte), 2 is blue
    function automatic logic [CHAN_W-1:0] pix_chan(input pixel_t p, input int ch);
        return p[PIX_W-1-ch*CHAN_W -: CHAN_W];
    endfunction

endpackage

// ===== rtl/core/rwb_ctrl.sv =====
module rwb_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rwb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rwb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            accept,
    input  logic                            action,
    output rwb_pkg::item_ctrl_t             item
);
    import rwb_pkg::*;

    logic [WIDTH_W-1:0]   width_reg, width_next;
    logic [HEIGHT_W-1:0]  height_reg, height_next;
    logic [COL_W-1:0]     in_col_reg, in_col_next;
    logic [IN_ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]     out_col_reg, out_col_next;
    logic [OUT_ROW_W-1:0] out_row_reg, out_row_next;

    logic restart;
    logic in_col_wrap;
    logic out_col_wrap;
    logic is_pixel;
    logic emit;
    logic last;

    assign cfg_ready = 1'b1;

    // Position decode for the item now at the input
    assign in_col_wrap  = (WIDTH_W'(in_col_reg) == width_reg - WIDTH_W'(1));
    assign out_col_wrap = (WIDTH_W'(out_col_reg) == width_reg - WIDTH_W'(1));
    assign is_pixel     = (in_row_reg < IN_ROW_W'(height_reg));
    // A result is due once width+1 items are in
    assign emit = (in_row_reg != '0) &&
                  ((in_row_reg != IN_ROW_W'(1)) || (in_col_reg != '0));
    // Item width*(height+1) closes the frame
    assign last = emit && (in_col_reg == '0) &&
                  (in_row_reg == IN_ROW_W'(height_reg) + IN_ROW_W'(1));

    always_comb
    begin
        item.drop          = is_pixel && (action == ACT_DRAIN);
        item.pixel         = is_pixel;
        item.col           = in_col_reg;
        item.win.emit      = emit;
        item.win.last      = last;
        item.win.at_left   = (out_col_reg == '0);
        item.win.at_right  = out_col_wrap;
        item.win.at_top    = (out_row_reg == '0);
        item.win.at_bottom = (HEIGHT_W'(out_row_reg) == height_reg - HEIGHT_W'(1));
    end

    // Register writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        restart     = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    width_next = clamp_width(cfg_data);
                    restart    = 1'b1;
                end
                REG_FRAME_HEIGHT:
                begin
                    height_next = clamp_height(cfg_data);
                    restart     = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // Frame position counters
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart || (accept && !item.drop && last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept && !item.drop)
        begin
            in_col_next = in_col_wrap ? '0 : in_col_reg + COL_W'(1);
            if (in_col_wrap)
                in_row_next = in_row_reg + IN_ROW_W'(1);
            if (emit)
            begin
                out_col_next = out_col_wrap ? '0 : out_col_reg + COL_W'(1);
                if (out_col_wrap)
                    out_row_next = out_row_reg + OUT_ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RST_WIDTH;
            height_reg  <= RST_HEIGHT;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

// ===== rtl/core/rwb_line_store.sv =====
module rwb_line_store (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [rwb_pkg::COL_W-1:0]   rd_addr,
    output rwb_pkg::line_entry_t        rd_data,
    input  logic                        wr_en,
    input  logic [rwb_pkg::COL_W-1:0]   wr_addr,
    input  rwb_pkg::line_entry_t        wr_data
);
    import rwb_pkg::*;

    line_entry_t line_mem [MAX_WIDTH];
    line_entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[wr_addr] <= wr_data;
    end

    // Registered read; a same-edge write to the same column is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data_reg <= wr_data;
            else
                rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/rwb_filter.sv =====
module rwb_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  rwb_pkg::pixel_t     col_top,
    input  rwb_pkg::pixel_t     col_mid,
    input  rwb_pkg::pixel_t     col_bot,
    input  rwb_pkg::win_ctrl_t  col_ctrl,
    output logic                go,
    output logic                res_valid,
    input  logic                res_ready,
    output rwb_pkg::res_item_t  res_data
);
    import rwb_pkg::*;

    pixel_t    win_reg [WIN_N];
    pixel_t    win_next [WIN_N];
    logic      s2_valid_reg, s2_valid_next;
    win_ctrl_t s2_ctrl_reg, s2_ctrl_next;
    logic      res_valid_reg, res_valid_next;
    res_item_t res_data_reg, res_data_next;

    logic                 out_free;
    logic [1:0]           col_sel [WIN_SIDE];
    logic [1:0]           row_sel [WIN_SIDE];
    pixel_t               tap [WIN_SIDE][WIN_SIDE];
    logic [SUM_W-1:0]     acc [NUM_CHAN];

    function automatic logic [WIN_IDX_W-1:0] win_idx(input logic [1:0] c,
                                                      input logic [1:0] r);
        return WIN_IDX_W'(c) * WIN_IDX_W'(WIN_SIDE) + WIN_IDX_W'(r);
    endfunction

    // Stage advance
    assign out_free = !res_valid_reg || res_ready;
    assign go       = !s2_valid_reg || out_free;

    // Column window shift, newest column on the right
    always_comb
    begin
        for (int i = 0; i < WIN_N; i++)
            win_next[i] = win_reg[i];
        if (shift)
        begin
            for (int i = 0; i < WIN_N - WIN_SIDE; i++)
                win_next[i] = win_reg[i + WIN_SIDE];
            win_next[WIN_N-3] = col_top;
            win_next[WIN_N-2] = col_mid;
            win_next[WIN_N-1] = col_bot;
        end
    end

    // Result stage control
    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        s2_ctrl_next  = s2_ctrl_reg;
        if (go)
        begin
            s2_valid_next = shift && col_ctrl.emit;
            s2_ctrl_next  = col_ctrl;
        end
    end

    // Edge replication: outside taps fall back to the center row or column
    always_comb
    begin
        col_sel[0] = s2_ctrl_reg.at_left   ? 2'd1 : 2'd0;
        col_sel[1] = 2'd1;
        col_sel[2] = s2_ctrl_reg.at_right  ? 2'd1 : 2'd2;
        row_sel[0] = s2_ctrl_reg.at_top    ? 2'd1 : 2'd0;
        row_sel[1] = 2'd1;
        row_sel[2] = s2_ctrl_reg.at_bottom ? 2'd1 : 2'd2;
        for (int c = 0; c < WIN_SIDE; c++)
            for (int r = 0; r < WIN_SIDE; r++)
                tap[c][r] = win_reg[win_idx(col_sel[c], row_sel[r])];
    end

    // 8*center + neighbors, per channel
    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            acc[ch] = SUM_W'(pix_chan(tap[1][1], ch)) << 3;
            for (int c = 0; c < WIN_SIDE; c++)
                for (int r = 0; r < WIN_SIDE; r++)
                    if (!((c == 1) && (r == 1)))
                        acc[ch] = acc[ch] + SUM_W'(pix_chan(tap[c][r], ch));
        end
    end

    // Output register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (out_free)
        begin
            res_valid_next              = s2_valid_reg;
            res_data_next.out_red       = acc[0][SUM_W-1 -: CHAN_W];
            res_data_next.out_green     = acc[1][SUM_W-1 -: CHAN_W];
            res_data_next.out_blue      = acc[2][SUM_W-1 -: CHAN_W];
            res_data_next.last_of_frame = s2_ctrl_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_N; i++)
                win_reg[i] <= '0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < WIN_N; i++)
                win_reg[i] <= win_next[i];
            s2_valid_reg  <= s2_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_ctrl_reg  <= s2_ctrl_next;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ===== rtl/core/rgb_3x3_weighted_blur.sv =====
// Streaming 3x3 center-weighted blur for RGB pixels in raster order: each
// channel of a result is (8*center + sum of the eight neighbors) >> 4, with
// neighbors outside the image replaced by the nearest edge pixel. Program
// frame_width (index 0) and frame_height (index 1) while idle; any write to
// either restarts the frame, 0 acts as 1 and values above 1024 act as 1024.
// A frame is width*height pixel transfers (action 0) followed by width+1
// drain transfers (action 1); result p comes out with the transfer of item
// p+width+1, and the final result of the frame has last_of_frame set. A drain
// sent while pixels are still expected is dropped; a pixel sent after the
// frame's pixels are in counts as a drain. The block takes one item per clock
// while pix_ready is high: a transfer reads one 48-bit entry (both stored rows)
// from a MAX_WIDTH-deep line memory; when the item leaves the input stage its
// entry is written back and the window shifts, and its result goes on through
// the window stage into the output register. pix_ready only drops while a result
// sits unaccepted in the output register with both the input stage and the
// window stage also full. No clearing pass after reset.
module rgb_3x3_weighted_blur (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    output logic                            pix_ready,
    input  rwb_pkg::pix_item_t              pix_data,
    output logic                            res_valid,
    input  logic                            res_ready,
    output rwb_pkg::res_item_t              res_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rwb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rwb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rwb_pkg::*;

    logic        accept;
    logic        go;
    logic        s1_go;
    logic        shift;
    item_ctrl_t  item;
    line_entry_t rd_entry;
    line_entry_t wr_entry;
    pixel_t      col_bot;

    logic        s1_valid_reg, s1_valid_next;
    item_ctrl_t  s1_ctrl_reg;
    pixel_t      s1_pixel_reg;

    assign s1_go     = !s1_valid_reg || go;
    assign pix_ready = s1_go;
    assign accept    = pix_valid && pix_ready;
    assign shift     = s1_valid_reg && go;

    // Frame position and register file
    rwb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .action    (pix_data.action),
        .item      (item)
    );

    // Input stage: dropped items never enter
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_go)
            s1_valid_next = accept && !item.drop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg  <= item;
            s1_pixel_reg <= {pix_data.in_red, pix_data.in_green, pix_data.in_blue};
        end
    end

    // New column: drain items repeat the middle row as the bottom
    assign col_bot = s1_ctrl_reg.pixel ? s1_pixel_reg : rd_entry.middle;

    always_comb
    begin
        wr_entry.upper  = rd_entry.middle;
        wr_entry.middle = s1_pixel_reg;
    end

    rwb_line_store u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (item.col),
        .rd_data (rd_entry),
        .wr_en   (shift && s1_ctrl_reg.pixel),
        .wr_addr (s1_ctrl_reg.col),
        .wr_data (wr_entry)
    );

    rwb_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift     (shift),
        .col_top   (rd_entry.upper),
        .col_mid   (rd_entry.middle),
        .col_bot   (col_bot),
        .col_ctrl  (s1_ctrl_reg.win),
        .go        (go),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

// ===== rtl/core/rwb_checker.sv =====
module rwb_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    input  logic                            pix_ready,
    input  rwb_pkg::pix_item_t              pix_data,
    input  logic                            res_valid,
    input  logic                            res_ready,
    input  rwb_pkg::res_item_t              res_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready
);

    // A waiting input transfer holds
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pix_data))
        else $error("input changed or dropped while waiting");

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed or dropped while stalled");

    // Input backpressure only comes from a stalled result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> res_valid && !res_ready)
        else $error("pix_ready low without output stall");

    // Nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid right after reset");

    // Configuration writes are never refused
    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind rgb_3x3_weighted_blur rwb_checker u_rwb_checker (.*);
